// File: hw/rtl/priority_task_scheduler_top_assert.svh
// Assertion macros for the priority task scheduler checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH

`define PTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pts_pkg.sv
// Shared types and constants for the priority task scheduler.
// Used by pts_cell and priority_task_scheduler_top; depends on nothing.
package pts_pkg;

    localparam int MAX_TASKS_DEF     = 16;
    localparam int PRIORITY_BITS_DEF = 4;
    localparam int TIME_BITS_DEF     = 32;
    localparam int MAX_TASKS_LIMIT   = 64;

    localparam int TASK_ID_W = 4;
    localparam int TABLE_W   = 64;
    localparam int SLOT_W    = $clog2(MAX_TASKS_LIMIT + 1);

    localparam logic KIND_ACTIVATE  = 1'b0;
    localparam logic KIND_TERMINATE = 1'b1;

    localparam logic STATUS_ACCEPT = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_REMOVE,
        CELL_APPEND
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [SLOT_W-1:0]     shift_from;
        logic [SLOT_W-1:0]     write_at;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/pts_cell.sv
// One slot of the ready-set ring: holds a task id, priority and activation time.
// Depends on pts_pkg for the control struct and the operation codes.
module pts_cell #(
    parameter int INDEX  = 0,
    parameter int PRIO_W = pts_pkg::PRIORITY_BITS_DEF,
    parameter int TIME_W = pts_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  pts_pkg::cell_ctrl_t           ctrl,
    input  logic [pts_pkg::TASK_ID_W-1:0] nb_id,
    input  logic [PRIO_W-1:0]             nb_prio,
    input  logic [TIME_W-1:0]             nb_stamp,
    input  logic [pts_pkg::TASK_ID_W-1:0] app_id,
    input  logic [PRIO_W-1:0]             app_prio,
    input  logic [TIME_W-1:0]             app_stamp,
    output logic [pts_pkg::TASK_ID_W-1:0] id,
    output logic [PRIO_W-1:0]             prio,
    output logic [TIME_W-1:0]             stamp
);
    import pts_pkg::*;

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    logic [TASK_ID_W-1:0] id_reg;
    logic [TASK_ID_W-1:0] id_next;
    logic [PRIO_W-1:0]    prio_reg;
    logic [PRIO_W-1:0]    prio_next;
    logic [TIME_W-1:0]    stamp_reg;
    logic [TIME_W-1:0]    stamp_next;
    logic                 take_nb;
    logic                 take_app;

    always_comb
    begin
        take_nb  = 1'b0;
        take_app = 1'b0;
        case (ctrl.op)
            CELL_ROTATE: take_nb  = 1'b1;
            CELL_REMOVE: take_nb  = (MY_SLOT >= ctrl.shift_from);
            CELL_APPEND: take_app = (MY_SLOT == ctrl.write_at);
            default:
            begin
                take_nb  = 1'b0;
                take_app = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        id_next    = id_reg;
        prio_next  = prio_reg;
        stamp_next = stamp_reg;
        if (take_app)
        begin
            id_next    = app_id;
            prio_next  = app_prio;
            stamp_next = app_stamp;
        end
        else if (take_nb)
        begin
            id_next    = nb_id;
            prio_next  = nb_prio;
            stamp_next = nb_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        prio_reg  <= prio_next;
        stamp_reg <= stamp_next;
    end

    assign id    = id_reg;
    assign prio  = prio_reg;
    assign stamp = stamp_reg;

endmodule

// File: hw/rtl/priority_task_scheduler_top.sv
// Priority task scheduler top level: a ring of pts_cell slots and the request sequencer.
// An activate request, and an accepted terminate request while tasks wait, is resolved by one
// full rotation of the ring past its single comparison slot; other terminates skip the scan.
// One request is in work at a time; the next can be taken in the cycle its result is presented.
// Reset (rst_n low, asynchronous) empties the ready set and stops the running task.
module priority_task_scheduler_top #(
    parameter int MAX_TASKS     = pts_pkg::MAX_TASKS_DEF,
    parameter int PRIORITY_BITS = pts_pkg::PRIORITY_BITS_DEF,
    parameter int TIME_BITS     = pts_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pts_pkg::TABLE_W-1:0]   priority_table,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [pts_pkg::TASK_ID_W-1:0] task_id,
    input  logic                          holds_resource,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic                          running_valid,
    output logic [pts_pkg::TASK_ID_W-1:0] running_id,
    output logic                          switched
);
    import pts_pkg::*;

    localparam int POS_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int SH_W  = $clog2(((1 << TASK_ID_W) - 1) * PRIORITY_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_REMOVE,
        S_APPEND_NEW,
        S_APPEND_RUN,
        S_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    logic [TABLE_W-1:0]       table_reg, table_next;
    logic                     kind_reg, kind_next;
    logic [TASK_ID_W-1:0]     id_reg, id_next;
    logic [PRIORITY_BITS-1:0] new_prio_reg, new_prio_next;
    logic [TIME_BITS-1:0]     clock_reg, clock_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic                     dup_reg, dup_next;
    logic                     best_valid_reg, best_valid_next;
    logic [POS_W-1:0]         best_idx_reg, best_idx_next;
    logic [TASK_ID_W-1:0]     best_id_reg, best_id_next;
    logic [PRIORITY_BITS-1:0] best_prio_reg, best_prio_next;
    logic [TIME_BITS-1:0]     best_stamp_reg, best_stamp_next;
    logic [CNT_W-1:0]         total_reg, total_next;
    logic                     run_valid_reg, run_valid_next;
    logic [TASK_ID_W-1:0]     run_id_reg, run_id_next;
    logic [PRIORITY_BITS-1:0] run_prio_reg, run_prio_next;
    logic [TIME_BITS-1:0]     run_stamp_reg, run_stamp_next;
    logic [TASK_ID_W-1:0]     disp_id_reg, disp_id_next;
    logic [PRIORITY_BITS-1:0] disp_prio_reg, disp_prio_next;
    logic [TIME_BITS-1:0]     disp_stamp_reg, disp_stamp_next;
    logic                     app_run_reg, app_run_next;
    logic                     pend_status_reg, pend_status_next;
    logic                     pend_switched_reg, pend_switched_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     status_reg, status_next;
    logic                     out_run_valid_reg, out_run_valid_next;
    logic [TASK_ID_W-1:0]     out_run_id_reg, out_run_id_next;
    logic                     switched_reg, switched_next;

    logic [TASK_ID_W-1:0]     cell_id    [MAX_TASKS];
    logic [PRIORITY_BITS-1:0] cell_prio  [MAX_TASKS];
    logic [TIME_BITS-1:0]     cell_stamp [MAX_TASKS];
    cell_ctrl_t               ctrl;
    logic [TASK_ID_W-1:0]     app_id;
    logic [PRIORITY_BITS-1:0] app_prio;
    logic [TIME_BITS-1:0]     app_stamp;

    logic [SH_W-1:0]          shift_amt;
    logic [TABLE_W-1:0]       table_shifted;
    logic [PRIORITY_BITS-1:0] lookup_prio;
    logic                     head_better;
    logic                     new_wins;
    logic [TASK_ID_W-1:0]     sel_id;
    logic [PRIORITY_BITS-1:0] sel_prio;
    logic [TIME_BITS-1:0]     sel_stamp;
    logic                     preempt;
    logic                     reject;
    logic                     out_load;

    genvar k;
    generate
        for (k = 0; k < MAX_TASKS; k++)
        begin : g_cell
            pts_cell #(
                .INDEX  (k),
                .PRIO_W (PRIORITY_BITS),
                .TIME_W (TIME_BITS)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .nb_id     (cell_id[(k + 1) % MAX_TASKS]),
                .nb_prio   (cell_prio[(k + 1) % MAX_TASKS]),
                .nb_stamp  (cell_stamp[(k + 1) % MAX_TASKS]),
                .app_id    (app_id),
                .app_prio  (app_prio),
                .app_stamp (app_stamp),
                .id        (cell_id[k]),
                .prio      (cell_prio[k]),
                .stamp     (cell_stamp[k])
            );
        end
    endgenerate

    assign shift_amt     = SH_W'(task_id) * SH_W'(PRIORITY_BITS);
    assign table_shifted = table_reg >> shift_amt;
    assign lookup_prio   = (32'(shift_amt) >= 32'(TABLE_W)) ? '0
                                                            : table_shifted[PRIORITY_BITS-1:0];

    assign head_better = (cell_prio[0] > best_prio_reg) ||
                         ((cell_prio[0] == best_prio_reg) && (cell_stamp[0] < best_stamp_reg));
    assign new_wins    = !best_valid_reg || (new_prio_reg > best_prio_reg) ||
                         ((new_prio_reg == best_prio_reg) && (clock_reg < best_stamp_reg));
    assign sel_id      = new_wins ? id_reg : best_id_reg;
    assign sel_prio    = new_wins ? new_prio_reg : best_prio_reg;
    assign sel_stamp   = new_wins ? clock_reg : best_stamp_reg;
    assign preempt     = (sel_prio > run_prio_reg) ||
                         ((sel_prio == run_prio_reg) && (sel_stamp < run_stamp_reg));
    assign reject      = dup_reg || (run_valid_reg && (run_id_reg == id_reg)) ||
                         (total_reg == CNT_W'(MAX_TASKS));
    assign out_load    = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        ctrl.shift_from = SLOT_W'(best_idx_reg);
        ctrl.write_at   = SLOT_W'(total_reg);
        case (state_reg)
            S_SCAN:       ctrl.op = CELL_ROTATE;
            S_REMOVE:     ctrl.op = CELL_REMOVE;
            S_APPEND_NEW: ctrl.op = CELL_APPEND;
            S_APPEND_RUN: ctrl.op = CELL_APPEND;
            default:      ctrl.op = CELL_HOLD;
        endcase
        if (state_reg == S_APPEND_RUN)
        begin
            app_id    = disp_id_reg;
            app_prio  = disp_prio_reg;
            app_stamp = disp_stamp_reg;
        end
        else
        begin
            app_id    = id_reg;
            app_prio  = new_prio_reg;
            app_stamp = clock_reg;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        table_next         = table_reg;
        kind_next          = kind_reg;
        id_next            = id_reg;
        new_prio_next      = new_prio_reg;
        clock_next         = clock_reg;
        pos_next           = pos_reg;
        dup_next           = dup_reg;
        best_valid_next    = best_valid_reg;
        best_idx_next      = best_idx_reg;
        best_id_next       = best_id_reg;
        best_prio_next     = best_prio_reg;
        best_stamp_next    = best_stamp_reg;
        total_next         = total_reg;
        run_valid_next     = run_valid_reg;
        run_id_next        = run_id_reg;
        run_prio_next      = run_prio_reg;
        run_stamp_next     = run_stamp_reg;
        disp_id_next       = disp_id_reg;
        disp_prio_next     = disp_prio_reg;
        disp_stamp_next    = disp_stamp_reg;
        app_run_next       = app_run_reg;
        pend_status_next   = pend_status_reg;
        pend_switched_next = pend_switched_reg;
        out_valid_next     = out_valid_reg;
        status_next        = status_reg;
        out_run_valid_next = out_run_valid_reg;
        out_run_id_next    = out_run_id_reg;
        switched_next      = switched_reg;

        if (cfg_valid)
        begin
            table_next = priority_table;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next          = kind;
                    id_next            = task_id;
                    new_prio_next      = lookup_prio;
                    pos_next           = '0;
                    dup_next           = 1'b0;
                    best_valid_next    = 1'b0;
                    app_run_next       = 1'b0;
                    pend_status_next   = STATUS_ACCEPT;
                    pend_switched_next = 1'b0;
                    if (kind == KIND_ACTIVATE)
                    begin
                        if (clock_reg != '1)
                        begin
                            clock_next = clock_reg + TIME_BITS'(1);
                        end
                        state_next = S_SCAN;
                    end
                    else if (!run_valid_reg || holds_resource)
                    begin
                        pend_status_next = STATUS_REJECT;
                        state_next       = S_FINISH;
                    end
                    else if (total_reg == '0)
                    begin
                        pend_switched_next = 1'b1;
                        run_valid_next     = 1'b0;
                        run_id_next        = '0;
                        run_prio_next      = '0;
                        run_stamp_next     = '0;
                        state_next         = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (CNT_W'(pos_reg) < total_reg)
                begin
                    if (cell_id[0] == id_reg)
                    begin
                        dup_next = 1'b1;
                    end
                    if (!best_valid_reg || head_better)
                    begin
                        best_valid_next = 1'b1;
                        best_idx_next   = pos_reg;
                        best_id_next    = cell_id[0];
                        best_prio_next  = cell_prio[0];
                        best_stamp_next = cell_stamp[0];
                    end
                end
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg == POS_W'(MAX_TASKS - 1))
                begin
                    state_next = S_RESOLVE;
                end
            end

            S_RESOLVE:
            begin
                if (kind_reg == KIND_TERMINATE)
                begin
                    pend_switched_next = 1'b1;
                    run_valid_next     = 1'b1;
                    run_id_next        = best_id_reg;
                    run_prio_next      = best_prio_reg;
                    run_stamp_next     = best_stamp_reg;
                    state_next         = S_REMOVE;
                end
                else if (reject)
                begin
                    pend_status_next = STATUS_REJECT;
                    state_next       = S_FINISH;
                end
                else if (!run_valid_reg || preempt)
                begin
                    pend_switched_next = 1'b1;
                    run_valid_next     = 1'b1;
                    run_id_next        = sel_id;
                    run_prio_next      = sel_prio;
                    run_stamp_next     = sel_stamp;
                    disp_id_next       = run_id_reg;
                    disp_prio_next     = run_prio_reg;
                    disp_stamp_next    = run_stamp_reg;
                    app_run_next       = run_valid_reg;
                    if (new_wins)
                    begin
                        state_next = run_valid_reg ? S_APPEND_RUN : S_FINISH;
                    end
                    else
                    begin
                        state_next = S_REMOVE;
                    end
                end
                else
                begin
                    state_next = S_APPEND_NEW;
                end
            end

            S_REMOVE:
            begin
                total_next = total_reg - CNT_W'(1);
                state_next = (kind_reg == KIND_TERMINATE) ? S_FINISH : S_APPEND_NEW;
            end

            S_APPEND_NEW:
            begin
                total_next = total_reg + CNT_W'(1);
                state_next = app_run_reg ? S_APPEND_RUN : S_FINISH;
            end

            S_APPEND_RUN:
            begin
                total_next = total_reg + CNT_W'(1);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = pend_status_reg;
                    out_run_valid_next = run_valid_reg;
                    out_run_id_next    = run_valid_reg ? run_id_reg : '0;
                    switched_next      = pend_switched_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            table_reg         <= '0;
            kind_reg          <= KIND_ACTIVATE;
            id_reg            <= '0;
            new_prio_reg      <= '0;
            clock_reg         <= '0;
            pos_reg           <= '0;
            dup_reg           <= 1'b0;
            best_valid_reg    <= 1'b0;
            best_idx_reg      <= '0;
            best_id_reg       <= '0;
            best_prio_reg     <= '0;
            best_stamp_reg    <= '0;
            total_reg         <= '0;
            run_valid_reg     <= 1'b0;
            run_id_reg        <= '0;
            run_prio_reg      <= '0;
            run_stamp_reg     <= '0;
            disp_id_reg       <= '0;
            disp_prio_reg     <= '0;
            disp_stamp_reg    <= '0;
            app_run_reg       <= 1'b0;
            pend_status_reg   <= STATUS_ACCEPT;
            pend_switched_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            status_reg        <= STATUS_ACCEPT;
            out_run_valid_reg <= 1'b0;
            out_run_id_reg    <= '0;
            switched_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            table_reg         <= table_next;
            kind_reg          <= kind_next;
            id_reg            <= id_next;
            new_prio_reg      <= new_prio_next;
            clock_reg         <= clock_next;
            pos_reg           <= pos_next;
            dup_reg           <= dup_next;
            best_valid_reg    <= best_valid_next;
            best_idx_reg      <= best_idx_next;
            best_id_reg       <= best_id_next;
            best_prio_reg     <= best_prio_next;
            best_stamp_reg    <= best_stamp_next;
            total_reg         <= total_next;
            run_valid_reg     <= run_valid_next;
            run_id_reg        <= run_id_next;
            run_prio_reg      <= run_prio_next;
            run_stamp_reg     <= run_stamp_next;
            disp_id_reg       <= disp_id_next;
            disp_prio_reg     <= disp_prio_next;
            disp_stamp_reg    <= disp_stamp_next;
            app_run_reg       <= app_run_next;
            pend_status_reg   <= pend_status_next;
            pend_switched_reg <= pend_switched_next;
            out_valid_reg     <= out_valid_next;
            status_reg        <= status_next;
            out_run_valid_reg <= out_run_valid_next;
            out_run_id_reg    <= out_run_id_next;
            switched_reg      <= switched_next;
        end
    end

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign running_valid = out_run_valid_reg;
    assign running_id    = out_run_id_reg;
    assign switched      = switched_reg;

endmodule

// File: hw/rtl/pts_checker.sv
// Port-level checker for priority_task_scheduler_top, attached by the bind below.
// Depends on the assertion macros in priority_task_scheduler_top_assert.svh.
`include "priority_task_scheduler_top_assert.svh"

module pts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       status,
    input logic       running_valid,
    input logic [3:0] running_id,
    input logic       switched
);

    `PTS_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(status) && $stable(running_valid) && $stable(running_id) && $stable(switched), "Result changed while stalled.")

    `PTS_ASSERT_NOW(a_idle_id_zero, out_valid && !running_valid, running_id == 4'd0, "Idle result carries a non-zero task id.")

    `PTS_ASSERT_NOW(a_reject_no_switch, out_valid && status, !switched, "Rejected request reports a task switch.")

    `PTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "Scheduler took a new request while one is in work.")

endmodule

bind priority_task_scheduler_top pts_checker u_pts_checker (.*);

// File: bench/priority_task_scheduler_checker.sv
`timescale 1ns / 1ps
// Result checker for the priority task scheduler: it follows the configuration, request and
// result channels, keeps its own copy of the ready set and running task, and compares results.
// Depends on pts_pkg for field widths and request and status codes.
module priority_task_scheduler_checker #(
    parameter int MAX_TASKS     = pts_pkg::MAX_TASKS_DEF,
    parameter int PRIORITY_BITS = pts_pkg::PRIORITY_BITS_DEF,
    parameter int TIME_BITS     = pts_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [pts_pkg::TABLE_W-1:0]   priority_table,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          kind,
    input  logic [pts_pkg::TASK_ID_W-1:0] task_id,
    input  logic                          holds_resource,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          status,
    input  logic                          running_valid,
    input  logic [pts_pkg::TASK_ID_W-1:0] running_id,
    input  logic                          switched,
    output int                            failures,
    output int                            outstanding,
    output int                            results_checked
);
    import pts_pkg::*;

    typedef struct packed {
        logic                 status;
        logic                 running_valid;
        logic [TASK_ID_W-1:0] running_id;
        logic                 switched;
    } sched_result_t;

    logic [TABLE_W-1:0]       prio_table;
    logic [TASK_ID_W-1:0]     queued_id   [MAX_TASKS];
    logic [PRIORITY_BITS-1:0] queued_prio [MAX_TASKS];
    logic [TIME_BITS-1:0]     queued_time [MAX_TASKS];
    int                       queued_count;
    logic                     cur_valid;
    logic [TASK_ID_W-1:0]     cur_id;
    logic [PRIORITY_BITS-1:0] cur_prio;
    logic [TIME_BITS-1:0]     cur_time;
    logic [TIME_BITS-1:0]     activation_time;
    sched_result_t            expected_q[$];
    int                       mismatch_total;
    int                       checked_total;

    function automatic logic [PRIORITY_BITS-1:0] priority_of(input logic [TASK_ID_W-1:0] id);
        int                 shift;
        logic [TABLE_W-1:0] shifted;
        shift = int'(id) * PRIORITY_BITS;
        if (shift >= TABLE_W)
        begin
            return '0;
        end
        shifted = prio_table >> shift;
        return shifted[PRIORITY_BITS-1:0];
    endfunction

    function automatic int best_slot();
        int b;
        b = 0;
        for (int i = 1; i < queued_count; i++)
        begin
            if (queued_prio[i] > queued_prio[b] ||
                (queued_prio[i] == queued_prio[b] && queued_time[i] < queued_time[b]))
            begin
                b = i;
            end
        end
        return b;
    endfunction

    task automatic remove_slot(input int k);
        for (int i = k; i + 1 < queued_count; i++)
        begin
            queued_id[i]   = queued_id[i + 1];
            queued_prio[i] = queued_prio[i + 1];
            queued_time[i] = queued_time[i + 1];
        end
        if (queued_count > 0)
        begin
            queued_count--;
        end
    endtask

    task automatic append_slot(input logic [TASK_ID_W-1:0] id,
                               input logic [PRIORITY_BITS-1:0] p,
                               input logic [TIME_BITS-1:0] t);
        if (queued_count < MAX_TASKS)
        begin
            queued_id[queued_count]   = id;
            queued_prio[queued_count] = p;
            queued_time[queued_count] = t;
            queued_count++;
        end
    endtask

    task automatic dispatch_best();
        int b;
        b = best_slot();
        cur_id    = queued_id[b];
        cur_prio  = queued_prio[b];
        cur_time  = queued_time[b];
        cur_valid = 1'b1;
        remove_slot(b);
    endtask

    task automatic schedule_request(input logic k, input logic [TASK_ID_W-1:0] id,
                                    input logic res, output sched_result_t r);
        logic                     reject;
        int                       b;
        logic [TASK_ID_W-1:0]     new_id;
        logic [PRIORITY_BITS-1:0] new_prio;
        logic [TIME_BITS-1:0]     new_time;
        r = '0;
        r.status = STATUS_ACCEPT;
        if (k == KIND_ACTIVATE)
        begin
            reject = 1'b0;
            if (activation_time != '1)
            begin
                activation_time = activation_time + 1'b1;
            end
            if (cur_valid && cur_id == id)
            begin
                reject = 1'b1;
            end
            for (int i = 0; i < queued_count; i++)
            begin
                if (queued_id[i] == id)
                begin
                    reject = 1'b1;
                end
            end
            if (queued_count >= MAX_TASKS)
            begin
                reject = 1'b1;
            end
            if (reject)
            begin
                r.status = STATUS_REJECT;
            end
            else
            begin
                append_slot(id, priority_of(id), activation_time);
                if (!cur_valid)
                begin
                    dispatch_best();
                    r.switched = 1'b1;
                end
                else
                begin
                    b = best_slot();
                    if (queued_prio[b] > cur_prio ||
                        (queued_prio[b] == cur_prio && queued_time[b] < cur_time))
                    begin
                        new_id   = queued_id[b];
                        new_prio = queued_prio[b];
                        new_time = queued_time[b];
                        remove_slot(b);
                        append_slot(cur_id, cur_prio, cur_time);
                        cur_id     = new_id;
                        cur_prio   = new_prio;
                        cur_time   = new_time;
                        r.switched = 1'b1;
                    end
                end
            end
        end
        else if (!cur_valid || res)
        begin
            r.status = STATUS_REJECT;
        end
        else
        begin
            r.switched = 1'b1;
            if (queued_count > 0)
            begin
                dispatch_best();
            end
            else
            begin
                cur_valid = 1'b0;
                cur_id    = '0;
                cur_prio  = '0;
                cur_time  = '0;
            end
        end
        r.running_valid = cur_valid;
        r.running_id    = cur_valid ? cur_id : '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t got;
        sched_result_t want;
        sched_result_t predicted;
        if (!rst_n)
        begin
            prio_table      = '0;
            queued_count    = 0;
            cur_valid       = 1'b0;
            cur_id          = '0;
            cur_prio        = '0;
            cur_time        = '0;
            activation_time = '0;
            mismatch_total  = 0;
            checked_total   = 0;
            expected_q.delete();
            failures        <= 0;
            outstanding     <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                prio_table = priority_table;
            end
            if (out_valid && out_ready)
            begin
                got.status        = status;
                got.running_valid = running_valid;
                got.running_id    = running_id;
                got.switched      = switched;
                if (expected_q.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                    begin
                        $display("Result with no request waiting: %s %0b %s %0b %s %0d %s %0b",
                                 "status=", got.status, "run=", got.running_valid,
                                 "id=", got.running_id, "sw=", got.switched);
                    end
                end
                else
                begin
                    want = expected_q.pop_front();
                    checked_total++;
                    if (got.status !== want.status || got.running_valid !== want.running_valid ||
                        got.running_id !== want.running_id || got.switched !== want.switched)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= 10)
                        begin
                            $display("Mismatch on result %0d: expected %s",
                                     checked_total, "status/run/id/sw as below");
                            $display("  expected status=%0b run=%0b id=%0d sw=%0b",
                                     want.status, want.running_valid,
                                     want.running_id, want.switched);
                            $display("  got      status=%0b run=%0b id=%0d sw=%0b",
                                     got.status, got.running_valid,
                                     got.running_id, got.switched);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                schedule_request(kind, task_id, holds_resource, predicted);
                expected_q.push_back(predicted);
            end
            failures        <= mismatch_total;
            outstanding     <= expected_q.size();
            results_checked <= checked_total;
        end
    end

endmodule

// File: bench/priority_task_scheduler_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the priority task scheduler: drives configuration and requests, stalls the
// result side, and gives the verdict. Depends on pts_pkg, priority_task_scheduler_top and the checker.
module priority_task_scheduler_top_test;
    import pts_pkg::*;

    localparam int PERIOD      = 10;
    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 113;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic [TABLE_W-1:0]   priority_table = '0;
    logic                 in_valid       = 1'b0;
    logic                 kind           = KIND_ACTIVATE;
    logic [TASK_ID_W-1:0] task_id        = '0;
    logic                 holds_resource = 1'b0;
    logic                 out_ready      = 1'b0;
    logic                 cfg_ready;
    logic                 in_ready;
    logic                 out_valid;
    logic                 status;
    logic                 running_valid;
    logic [TASK_ID_W-1:0] running_id;
    logic                 switched;

    int failures;
    int outstanding;
    int results_checked;
    int items_sent      = 0;
    int activates_sent  = 0;
    int terminates_sent = 0;
    int tables_loaded   = 0;
    int rx_cycles       = 0;
    int results_taken   = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;
    int stuck_cycles    = 0;

    always #(PERIOD / 2) clk = ~clk;

    priority_task_scheduler_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .priority_table (priority_table),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .task_id        (task_id),
        .holds_resource (holds_resource),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .running_valid  (running_valid),
        .running_id     (running_id),
        .switched       (switched)
    );

    priority_task_scheduler_checker sched_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .priority_table  (priority_table),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .task_id         (task_id),
        .holds_resource  (holds_resource),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .running_valid   (running_valid),
        .running_id      (running_id),
        .switched        (switched),
        .failures        (failures),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // Once, the result side holds off long enough for a request to back up behind it.
    always @(posedge clk)
    begin
        rx_cycles <= rx_cycles + 1;
        if (out_valid && out_ready)
        begin
            results_taken <= results_taken + 1;
        end
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_taken >= HOLD_AFTER)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_ready <= (rx_cycles >= 9000 && rx_cycles < 12000) || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic offer_request(input logic k, input logic [TASK_ID_W-1:0] id, input logic res);
        while (!(items_sent >= 300 && items_sent < 420) && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        task_id        <= id;
        holds_resource <= res;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (k == KIND_ACTIVATE)
        begin
            activates_sent++;
        end
        else
        begin
            terminates_sent++;
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic load_priorities(input logic [TABLE_W-1:0] value);
        cfg_valid      <= 1'b1;
        priority_table <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tables_loaded++;
    endtask

    task automatic run_phase(input logic [TABLE_W-1:0] table_value, input int count);
        int   activate_pct;
        logic k;
        drain_results();
        load_priorities(table_value);
        activate_pct = $urandom_range(45, 75);
        repeat (count)
        begin
            k = ($urandom_range(99) < activate_pct) ? KIND_ACTIVATE : KIND_TERMINATE;
            offer_request(k, TASK_ID_W'($urandom_range(15)), $urandom_range(99) < 15);
        end
    endtask

    initial
    begin
        logic [TABLE_W-1:0] two_level;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_priorities(64'hFEDC_BA98_7654_3210);
        offer_request(KIND_TERMINATE, 4'd0, 1'b0);
        offer_request(KIND_TERMINATE, 4'd15, 1'b1);
        offer_request(KIND_ACTIVATE, 4'd5, 1'b0);
        offer_request(KIND_ACTIVATE, 4'd5, 1'b0);
        offer_request(KIND_ACTIVATE, 4'd3, 1'b1);
        offer_request(KIND_ACTIVATE, 4'd3, 1'b0);
        offer_request(KIND_ACTIVATE, 4'd15, 1'b0);
        offer_request(KIND_TERMINATE, 4'd0, 1'b1);
        offer_request(KIND_TERMINATE, 4'd0, 1'b0);
        offer_request(KIND_ACTIVATE, 4'd0, 1'b0);
        offer_request(KIND_TERMINATE, 4'd10, 1'b0);
        offer_request(KIND_TERMINATE, 4'd0, 1'b0);
        offer_request(KIND_TERMINATE, 4'd0, 1'b0);
        offer_request(KIND_TERMINATE, 4'd0, 1'b0);

        drain_results();
        load_priorities('1);
        offer_request(KIND_ACTIVATE, 4'd9, 1'b0);
        offer_request(KIND_ACTIVATE, 4'd10, 1'b0);
        offer_request(KIND_ACTIVATE, 4'd1, 1'b0);
        offer_request(KIND_TERMINATE, 4'd0, 1'b0);
        offer_request(KIND_TERMINATE, 4'd0, 1'b0);
        offer_request(KIND_TERMINATE, 4'd0, 1'b0);

        two_level = '0;
        for (int i = 0; i < TABLE_W / 4; i++)
        begin
            two_level[4 * i +: 4] = $urandom_range(1) ? 4'hF : 4'h0;
        end
        run_phase('0, PHASE_ITEMS);
        run_phase('1, PHASE_ITEMS);
        run_phase(64'h0123_4567_89AB_CDEF, PHASE_ITEMS);
        run_phase(64'hFEDC_BA98_7654_3210, PHASE_ITEMS);
        run_phase({$urandom, $urandom}, PHASE_ITEMS);
        run_phase(two_level, PHASE_ITEMS);

        drain_results();
        repeat (30) @(posedge clk);
        $display("Sent %0d requests (%0d activations, %0d terminations) across %0d priority tables.",
                 items_sent, activates_sent, terminates_sent, tables_loaded);
        $display("%0d results were compared against the predicted schedule.", results_checked);
        if (failures == 0 && outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
